[rtl/sriosc_pkg.sv]
package sriosc_pkg;

    // Chain geometry
    localparam int OUT_CHAINS = 2;
    localparam int BYTE_W     = 8;
    localparam int BIT_IDX_W  = 3;
    localparam int CHAIN_W    = 1;
    localparam int PHASE_W    = 4;

    // Last phase of the sequence: latch, load and publish
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd15;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd0;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // Host beat kinds
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_SET   = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    // Pin levels, packed highest bit first; bit positions as on the result bus
    typedef struct packed {
        logic                  in_load;
        logic                  in_clock;
        logic                  out_latch;
        logic [OUT_CHAINS-1:0] out_data;
        logic                  out_clock;
    } pins_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

[rtl/shift_register_io_scanner.sv]
// An input beat reaches its result beat through the input register, then the
// result register; throughput: one beat per cycle while m_tready holds high, set
// by the single pass of phase and pin logic between the two registers.
// Each beat gives exactly one result beat; with both registers full a stalled
// result holds the input, which takes a beat again in the cycle the result frees.
// Reset (aresetn low, synchronous) clears all sequencer state; pins read low.
module shift_register_io_scanner (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] chain_index, [8:1] byte_value, [11:9] bit_index, [12] serial_in
    input  logic [sriosc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [sriosc_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] out_clock, [2:1] out_data, [3] out_latch, [4] in_clock,
    // [5] in_load, [13:6] captured_byte, [17:14] phase
    output logic [sriosc_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] capture_done
    output logic [sriosc_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int OC = sriosc_pkg::OUT_CHAINS;
    localparam int BW = sriosc_pkg::BYTE_W;
    localparam int PW = sriosc_pkg::PHASE_W;
    localparam int PINS_W = $bits(sriosc_pkg::pins_t);
    localparam int RES_W  = PINS_W + BW + PW;

    // Input register
    logic                                   in_valid_reg;
    sriosc_pkg::action_t                    action_reg;
    logic [sriosc_pkg::CHAIN_W-1:0]         chain_reg;
    sriosc_pkg::byte_t                      value_reg;
    logic [sriosc_pkg::BIT_IDX_W-1:0]       bit_reg;
    logic                                   serial_reg;

    // Sequencer state
    logic [PW-1:0]                          phase_reg, phase_next;
    sriosc_pkg::byte_t                      request_reg [OC];
    sriosc_pkg::byte_t                      request_next [OC];
    sriosc_pkg::byte_t                      sending_reg [OC];
    sriosc_pkg::byte_t                      sending_next [OC];
    sriosc_pkg::byte_t                      capture_reg, capture_next;
    sriosc_pkg::byte_t                      published_reg, published_next;
    sriosc_pkg::pins_t                      pins_reg, pins_next;
    logic                                   done_next;

    // Result register
    logic                                   out_valid_reg;
    logic [RES_W-1:0]                       out_data_reg;
    logic                                   out_done_reg;

    logic                                   advance;
    logic [sriosc_pkg::BIT_IDX_W-1:0]       pos;
    sriosc_pkg::byte_t                      mask;
    sriosc_pkg::byte_t                      send_src [OC];

    // Handshake: the input stage moves on whenever the result register frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            action_reg <= sriosc_pkg::action_t'(s_tuser[1:0]);
            chain_reg  <= s_tdata[0];
            value_reg  <= s_tdata[8:1];
            bit_reg    <= s_tdata[11:9];
            serial_reg <= s_tdata[12];
        end
    end

    // Bit position for this phase pair, MSB first
    assign pos  = ~phase_reg[PW-1:1];
    assign mask = sriosc_pkg::byte_t'(1) << bit_reg;

    // Phase step, pin levels and host request edits
    always_comb begin
        phase_next     = phase_reg;
        request_next   = request_reg;
        sending_next   = sending_reg;
        capture_next   = capture_reg;
        published_next = published_reg;
        pins_next      = pins_reg;
        done_next      = 1'b0;
        send_src       = sending_reg;

        unique case (action_reg)
            sriosc_pkg::ACT_TICK: begin
                if (phase_reg == sriosc_pkg::PHASE_FIRST) begin
                    sending_next        = request_reg;
                    send_src            = request_reg;
                    pins_next.out_latch = 1'b1;
                    pins_next.in_load   = 1'b0;
                end
                if (!phase_reg[0]) begin
                    pins_next.out_clock = 1'b0;
                    for (int n = 0; n < OC; n++) begin
                        pins_next.out_data[n] = send_src[n][pos];
                    end
                    pins_next.in_clock = 1'b1;
                end else begin
                    pins_next.out_clock = 1'b1;
                    capture_next[pos]   = capture_reg[pos] | serial_reg;
                    pins_next.in_clock  = (phase_reg == sriosc_pkg::PHASE_LAST);
                end
                if (phase_reg == sriosc_pkg::PHASE_LAST) begin
                    pins_next.out_latch = 1'b0;
                    pins_next.in_load   = 1'b1;
                    published_next      = capture_next;
                    capture_next        = '0;
                    done_next           = 1'b1;
                end
                phase_next = phase_reg + PW'(1);
            end
            sriosc_pkg::ACT_WRITE,
            sriosc_pkg::ACT_SET,
            sriosc_pkg::ACT_CLEAR: begin
                for (int n = 0; n < OC; n++) begin
                    if (32'(chain_reg) == n) begin
                        if (action_reg == sriosc_pkg::ACT_WRITE) begin
                            request_next[n] = value_reg;
                        end else if (action_reg == sriosc_pkg::ACT_SET) begin
                            request_next[n] = request_reg[n] | mask;
                        end else begin
                            request_next[n] = request_reg[n] & ~mask;
                        end
                    end
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // State registers, updated as a beat passes to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            capture_reg   <= '0;
            published_reg <= '0;
            pins_reg      <= '0;
            for (int n = 0; n < OC; n++) begin
                request_reg[n] <= '0;
                sending_reg[n] <= '0;
            end
        end else if (advance) begin
            phase_reg     <= phase_next;
            capture_reg   <= capture_next;
            published_reg <= published_next;
            pins_reg      <= pins_next;
            request_reg   <= request_next;
            sending_reg   <= sending_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= {phase_next, published_next, pins_next};
            out_done_reg <= done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(sriosc_pkg::M_TDATA_W - RES_W)'(0), out_data_reg};
    assign m_tuser  = out_done_reg;

`ifndef SYNTHESIS
    // A published capture always wraps the sequence back to phase zero
    a_done_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_done_reg |-> out_data_reg[RES_W-1 -: PW] == '0)
        else $error("capture done without phase wrap");

    // A tick steps the phase by one
    a_tick_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && action_reg == sriosc_pkg::ACT_TICK
        |=> phase_reg == $past(phase_reg) + PW'(1))
        else $error("tick did not advance phase");

    // Host edits leave the sequence and pins alone
    a_host_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && action_reg != sriosc_pkg::ACT_TICK
        |=> $stable(phase_reg) && $stable(pins_reg))
        else $error("host beat disturbed sequence");

    // Latch high and load high are never driven together
    a_latch_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pins_reg.out_latch && pins_reg.in_load))
        else $error("latch and load both high");
`endif

endmodule
